// ----- rtl/core/vssc_pkg.sv -----
// ----------------------------------------------------------------------------
// vssc_pkg
// Shared types, codes and arithmetic helpers for the Verlet spring step block.
// ----------------------------------------------------------------------------
package vssc_pkg;

  localparam int DEF_MAX_POINTS      = 1024;
  localparam int DEF_MAX_ATTACHMENTS = 1024;
  localparam int DEF_MAX_SPRINGS     = 1024;

  // item operations
  localparam logic [2:0] OP_LOAD_POINT  = 3'd0;
  localparam logic [2:0] OP_LOAD_ATTACH = 3'd1;
  localparam logic [2:0] OP_LOAD_SPRING = 3'd2;
  localparam logic [2:0] OP_ADVANCE     = 3'd3;
  localparam logic [2:0] OP_READ_POINT  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_POINT_COUNT  = 2'd0;
  localparam logic [1:0] CFG_ATTACH_COUNT = 2'd1;
  localparam logic [1:0] CFG_SPRING_COUNT = 2'd2;
  localparam logic [1:0] CFG_TIMESTEP     = 2'd3;

  localparam logic [10:0] RST_POINT_COUNT = 11'd1;
  localparam logic [15:0] RST_TIMESTEP    = 16'd1092;

  localparam logic [19:0] GRAVITY_Q16 = 20'd642908;
  localparam logic [40:0] DELTA_CAP   = 41'h100_0000_0000;

  localparam int SQRT_STEPS = 35;
  localparam int DIV_STEPS  = 69;

  // datapath commands
  localparam logic [4:0] CMD_NONE      = 5'd0;
  localparam logic [4:0] CMD_ACCEPT    = 5'd1;
  localparam logic [4:0] CMD_ADV_START = 5'd2;
  localparam logic [4:0] CMD_DROP      = 5'd3;
  localparam logic [4:0] CMD_V_RD      = 5'd4;
  localparam logic [4:0] CMD_V_WR      = 5'd5;
  localparam logic [4:0] CMD_A_RD      = 5'd6;
  localparam logic [4:0] CMD_A_WR      = 5'd7;
  localparam logic [4:0] CMD_S_RD      = 5'd8;
  localparam logic [4:0] CMD_S_PT      = 5'd9;
  localparam logic [4:0] CMD_S_V       = 5'd10;
  localparam logic [4:0] CMD_SQ        = 5'd11;
  localparam logic [4:0] CMD_SQRT_INIT = 5'd12;
  localparam logic [4:0] CMD_SQRT_STEP = 5'd13;
  localparam logic [4:0] CMD_DEGEN     = 5'd14;
  localparam logic [4:0] CMD_DIFF      = 5'd15;
  localparam logic [4:0] CMD_MUL_LO    = 5'd16;
  localparam logic [4:0] CMD_MUL_HI    = 5'd17;
  localparam logic [4:0] CMD_DIV_INIT  = 5'd18;
  localparam logic [4:0] CMD_DIV_STEP  = 5'd19;
  localparam logic [4:0] CMD_APPLY     = 5'd20;
  localparam logic [4:0] CMD_WR_A      = 5'd21;
  localparam logic [4:0] CMD_WR_B      = 5'd22;
  localparam logic [4:0] CMD_FIN       = 5'd23;

  typedef logic [2:0][31:0] pos_t;

  typedef struct packed {
    logic [4:0]  code;
    logic [10:0] idx;
    logic [1:0]  axis;
  } cmd_t;

  typedef struct packed {
    logic [10:0] np;
    logic [10:0] na;
    logic [10:0] ns;
    logic        spring_bad;
    logic        len_zero;
  } status_t;

  function automatic logic [31:0] sat32(input logic signed [43:0] v);
    logic [31:0] r;
    if (v > 44'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -44'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/verlet_spring_constraint_step_top.sv -----
// ----------------------------------------------------------------------------
// verlet_spring_constraint_step_top
// Rope/cloth point-mass stepper with attachment and spring constraints.
// ----------------------------------------------------------------------------
// load, read and unknown items: one per cycle while not busy, result strobe in the next cycle
// advance: busy through the Verlet, attachment and spring passes; per spring a
//   35-step square root and three 69-step divides, result after busy
// all store traffic goes through single write ports, one write per store per step
// synchronous active-low reset clears control, config and the result register, not the stores
// the result channel cannot stall; out_valid is a one-cycle strobe
module verlet_spring_constraint_step_top #(
  parameter int MAX_POINTS      = vssc_pkg::DEF_MAX_POINTS,
  parameter int MAX_ATTACHMENTS = vssc_pkg::DEF_MAX_ATTACHMENTS,
  parameter int MAX_SPRINGS     = vssc_pkg::DEF_MAX_SPRINGS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [9:0]  in_slot,
  input  logic [9:0]  in_point_a,
  input  logic [9:0]  in_point_b,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [30:0] in_rest_length,
  output logic        out_valid,
  output logic [9:0]  out_index,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [10:0] out_degenerate_springs,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  vssc_pkg::cmd_t    cmd;
  vssc_pkg::status_t st;

  assign cfg_ready = 1'b1;

  vssc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .st           (st),
    .busy         (busy),
    .cmd          (cmd)
  );

  vssc_dp #(
    .MAX_POINTS      (MAX_POINTS),
    .MAX_ATTACHMENTS (MAX_ATTACHMENTS),
    .MAX_SPRINGS     (MAX_SPRINGS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_operation           (in_operation),
    .in_slot                (in_slot),
    .in_point_a             (in_point_a),
    .in_point_b             (in_point_b),
    .in_pos_x               (in_pos_x),
    .in_pos_y               (in_pos_y),
    .in_pos_z               (in_pos_z),
    .in_rest_length         (in_rest_length),
    .out_valid              (out_valid),
    .out_index              (out_index),
    .out_x                  (out_x),
    .out_y                  (out_y),
    .out_z                  (out_z),
    .out_degenerate_springs (out_degenerate_springs)
  );

`ifndef SYNTHESIS
  // a non-advance transaction answers in the next cycle
  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation != vssc_pkg::OP_ADVANCE) |=> out_valid)
    else $error("missing result after load or read");

  // no result strobe while an advance is running
  a_quiet_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_valid)
    else $error("result strobe during advance");

  // an advance ends with its result
  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("advance finished without result");
`endif

endmodule

// ----- rtl/core/vssc_ctrl.sv -----
// ----------------------------------------------------------------------------
// vssc_ctrl
// Sequencer: accepts items and walks the Verlet, attachment and spring passes.
// ----------------------------------------------------------------------------
module vssc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [2:0]           in_operation,
  input  vssc_pkg::status_t    st,
  output logic                 busy,
  output vssc_pkg::cmd_t       cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_DROP   = 5'd1;
  localparam logic [4:0] ST_V_RD   = 5'd2;
  localparam logic [4:0] ST_V_WR   = 5'd3;
  localparam logic [4:0] ST_A_RD   = 5'd4;
  localparam logic [4:0] ST_A_WR   = 5'd5;
  localparam logic [4:0] ST_S_RD   = 5'd6;
  localparam logic [4:0] ST_S_PT   = 5'd7;
  localparam logic [4:0] ST_S_V    = 5'd8;
  localparam logic [4:0] ST_SQ     = 5'd9;
  localparam logic [4:0] ST_SQ_INI = 5'd10;
  localparam logic [4:0] ST_SQRT   = 5'd11;
  localparam logic [4:0] ST_CHK    = 5'd12;
  localparam logic [4:0] ST_MLO    = 5'd13;
  localparam logic [4:0] ST_MHI    = 5'd14;
  localparam logic [4:0] ST_DINIT  = 5'd15;
  localparam logic [4:0] ST_DIV    = 5'd16;
  localparam logic [4:0] ST_APPLY  = 5'd17;
  localparam logic [4:0] ST_WA     = 5'd18;
  localparam logic [4:0] ST_WB     = 5'd19;
  localparam logic [4:0] ST_FIN    = 5'd20;

  logic [4:0]  state_r, state_nxt;
  logic [10:0] idx_r, idx_nxt;
  logic [1:0]  axis_r, axis_nxt;
  logic [6:0]  step_r, step_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    axis_nxt  = axis_r;
    step_nxt  = step_r;
    cmd.code  = vssc_pkg::CMD_NONE;
    cmd.idx   = idx_r;
    cmd.axis  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == vssc_pkg::OP_ADVANCE) begin
            cmd.code  = vssc_pkg::CMD_ADV_START;
            state_nxt = ST_DROP;
          end else begin
            cmd.code = vssc_pkg::CMD_ACCEPT;
          end
        end
      end
      ST_DROP: begin
        cmd.code  = vssc_pkg::CMD_DROP;
        idx_nxt   = '0;
        state_nxt = ST_V_RD;
      end
      ST_V_RD: begin
        if (idx_r < st.np) begin
          cmd.code  = vssc_pkg::CMD_V_RD;
          state_nxt = ST_V_WR;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_A_RD;
        end
      end
      ST_V_WR: begin
        cmd.code  = vssc_pkg::CMD_V_WR;
        idx_nxt   = idx_r + 11'd1;
        state_nxt = ST_V_RD;
      end
      ST_A_RD: begin
        if (idx_r < st.na) begin
          cmd.code  = vssc_pkg::CMD_A_RD;
          state_nxt = ST_A_WR;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_S_RD;
        end
      end
      ST_A_WR: begin
        cmd.code  = vssc_pkg::CMD_A_WR;
        idx_nxt   = idx_r + 11'd1;
        state_nxt = ST_A_RD;
      end
      ST_S_RD: begin
        if (idx_r < st.ns) begin
          cmd.code  = vssc_pkg::CMD_S_RD;
          state_nxt = ST_S_PT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_S_PT: begin
        // spring naming a point outside the store is dropped silently
        if (st.spring_bad) begin
          idx_nxt   = idx_r + 11'd1;
          state_nxt = ST_S_RD;
        end else begin
          cmd.code  = vssc_pkg::CMD_S_PT;
          state_nxt = ST_S_V;
        end
      end
      ST_S_V: begin
        cmd.code  = vssc_pkg::CMD_S_V;
        axis_nxt  = '0;
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        cmd.code = vssc_pkg::CMD_SQ;
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd2) state_nxt = ST_SQ_INI;
      end
      ST_SQ_INI: begin
        cmd.code  = vssc_pkg::CMD_SQRT_INIT;
        step_nxt  = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.code = vssc_pkg::CMD_SQRT_STEP;
        step_nxt = step_r + 7'd1;
        if (step_r == 7'(vssc_pkg::SQRT_STEPS - 1)) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (st.len_zero) begin
          cmd.code  = vssc_pkg::CMD_DEGEN;
          idx_nxt   = idx_r + 11'd1;
          state_nxt = ST_S_RD;
        end else begin
          cmd.code  = vssc_pkg::CMD_DIFF;
          axis_nxt  = '0;
          state_nxt = ST_MLO;
        end
      end
      ST_MLO: begin
        cmd.code  = vssc_pkg::CMD_MUL_LO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        cmd.code  = vssc_pkg::CMD_MUL_HI;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.code  = vssc_pkg::CMD_DIV_INIT;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.code = vssc_pkg::CMD_DIV_STEP;
        step_nxt = step_r + 7'd1;
        if (step_r == 7'(vssc_pkg::DIV_STEPS - 1)) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.code = vssc_pkg::CMD_APPLY;
        axis_nxt = axis_r + 2'd1;
        if (axis_r == 2'd2) state_nxt = ST_WA;
        else state_nxt = ST_MLO;
      end
      ST_WA: begin
        cmd.code  = vssc_pkg::CMD_WR_A;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.code  = vssc_pkg::CMD_WR_B;
        idx_nxt   = idx_r + 11'd1;
        state_nxt = ST_S_RD;
      end
      ST_FIN: begin
        cmd.code  = vssc_pkg::CMD_FIN;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      axis_r  <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      axis_r  <= axis_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- rtl/core/vssc_dp.sv -----
// ----------------------------------------------------------------------------
// vssc_dp
// Datapath: point, attachment and spring stores, config registers, Verlet
// update, bit-serial square root and restoring divide.
// ----------------------------------------------------------------------------
module vssc_dp #(
  parameter int MAX_POINTS      = vssc_pkg::DEF_MAX_POINTS,
  parameter int MAX_ATTACHMENTS = vssc_pkg::DEF_MAX_ATTACHMENTS,
  parameter int MAX_SPRINGS     = vssc_pkg::DEF_MAX_SPRINGS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vssc_pkg::cmd_t       cmd,
  output vssc_pkg::status_t    st,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [2:0]           in_operation,
  input  logic [9:0]           in_slot,
  input  logic [9:0]           in_point_a,
  input  logic [9:0]           in_point_b,
  input  logic [31:0]          in_pos_x,
  input  logic [31:0]          in_pos_y,
  input  logic [31:0]          in_pos_z,
  input  logic [30:0]          in_rest_length,
  output logic                 out_valid,
  output logic [9:0]           out_index,
  output logic [31:0]          out_x,
  output logic [31:0]          out_y,
  output logic [31:0]          out_z,
  output logic [10:0]          out_degenerate_springs
);

  localparam int PAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int AAW = (MAX_ATTACHMENTS > 1) ? $clog2(MAX_ATTACHMENTS) : 1;
  localparam int SAW = (MAX_SPRINGS > 1) ? $clog2(MAX_SPRINGS) : 1;

  function automatic logic [43:0] ext32(input logic [31:0] v);
    return {{12{v[31]}}, v};
  endfunction

  // config registers
  logic [10:0] pc_r, ac_r, sc_r;
  logic [15:0] ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= vssc_pkg::RST_POINT_COUNT;
      ac_r <= '0;
      sc_r <= '0;
      ts_r <= vssc_pkg::RST_TIMESTEP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vssc_pkg::CFG_POINT_COUNT:  pc_r <= cfg_data[10:0];
        vssc_pkg::CFG_ATTACH_COUNT: ac_r <= cfg_data[10:0];
        vssc_pkg::CFG_SPRING_COUNT: sc_r <= cfg_data[10:0];
        vssc_pkg::CFG_TIMESTEP:     ts_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stores
  vssc_pkg::pos_t cur_mem  [MAX_POINTS];
  vssc_pkg::pos_t prev_mem [MAX_POINTS];
  logic [105:0]   att_mem  [MAX_ATTACHMENTS];
  logic [50:0]    spr_mem  [MAX_SPRINGS];

  logic               cur_we, prev_we, att_we, spr_we, cur_re, prev_re, att_re, spr_re;
  logic [PAW-1:0]     cur_wa, cur_ra1, cur_ra2, prev_a;
  logic [AAW-1:0]     att_a;
  logic [SAW-1:0]     spr_a;
  vssc_pkg::pos_t     cur_wd, prev_wd, cur_q1, cur_q2, prev_q;
  logic [105:0]       att_q;
  logic [50:0]        spr_q;

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_wa] <= cur_wd;
    if (cur_re) begin
      cur_q1 <= cur_mem[cur_ra1];
      cur_q2 <= cur_mem[cur_ra2];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_a] <= prev_wd;
    if (prev_re) prev_q <= prev_mem[prev_a];
  end

  always_ff @(posedge clk) begin
    if (att_we) att_mem[att_a] <= {in_point_a, in_pos_z, in_pos_y, in_pos_x};
    if (att_re) att_q <= att_mem[att_a];
  end

  always_ff @(posedge clk) begin
    if (spr_we) spr_mem[spr_a] <= {in_point_a, in_point_b, in_rest_length};
    if (spr_re) spr_q <= spr_mem[spr_a];
  end

  // working registers
  logic [16:0]        t2_r;
  logic [19:0]        drop_r;
  logic [9:0]         adv_slot_r;
  logic [10:0]        deg_r;
  logic [9:0]         sa_r, sb_r;
  logic [30:0]        rest_r;
  vssc_pkg::pos_t     pa_r, pb_r;
  logic signed [32:0] v_r [3];
  logic [65:0]        acc_r;
  logic [69:0]        src_r;
  logic [36:0]        rem_r;
  logic [34:0]        root_r;
  logic               diff_neg_r;
  logic [35:0]        dmag_r, dvs_r;
  logic [52:0]        mul_r;
  logic [68:0]        prod_r, num_r, q_r;
  logic [35:0]        drem_r;

  logic               out_valid_r, out_rd_r;
  logic [9:0]         out_index_r;
  logic [10:0]        out_deg_r;

  // combinational helpers
  logic               slot_pt_ok, slot_att_ok, slot_spr_ok, att_pt_ok;
  vssc_pkg::pos_t     in_pos, att_pos, verlet_pos;
  logic [9:0]         att_pt, spr_pa, spr_pb;
  logic [32:0]        vmag;
  logic signed [35:0] diff;
  logic [38:0]        sq_rem_sh, sq_trial;
  logic               sq_ge;
  logic [36:0]        dv_sh;
  logic               dv_ge;
  logic [40:0]        dcl;
  logic signed [41:0] sd;
  logic [31:0]        a_new, b_new;

  assign in_pos      = {in_pos_z, in_pos_y, in_pos_x};
  assign slot_pt_ok  = 32'(in_slot) < MAX_POINTS;
  assign slot_att_ok = 32'(in_slot) < MAX_ATTACHMENTS;
  assign slot_spr_ok = 32'(in_slot) < MAX_SPRINGS;
  assign att_pt      = att_q[105:96];
  assign att_pos     = att_q[95:0];
  assign att_pt_ok   = 32'(att_pt) < MAX_POINTS;
  assign spr_pa      = spr_q[50:41];
  assign spr_pb      = spr_q[40:31];

  assign st.np = (32'(pc_r) > MAX_POINTS) ? 11'(MAX_POINTS) : pc_r;
  assign st.na = (32'(ac_r) > MAX_ATTACHMENTS) ? 11'(MAX_ATTACHMENTS) : ac_r;
  assign st.ns = (32'(sc_r) > MAX_SPRINGS) ? 11'(MAX_SPRINGS) : sc_r;
  assign st.spring_bad = (32'(spr_pa) >= MAX_POINTS) || (32'(spr_pb) >= MAX_POINTS);
  assign st.len_zero   = (root_r == '0);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (j == 2) begin
        verlet_pos[j] = vssc_pkg::sat32($signed(ext32(cur_q1[j]) + ext32(cur_q1[j])
                        - ext32(prev_q[j]) - 44'(drop_r)));
      end else begin
        verlet_pos[j] = vssc_pkg::sat32($signed(ext32(cur_q1[j]) + ext32(cur_q1[j])
                        - ext32(prev_q[j])));
      end
    end
  end

  assign vmag = v_r[cmd.axis][32] ? 33'(-v_r[cmd.axis]) : 33'(v_r[cmd.axis]);
  assign diff = $signed({1'b0, root_r}) - $signed({5'b0, rest_r});

  assign sq_rem_sh = {rem_r, src_r[69:68]};
  assign sq_trial  = {2'b00, root_r, 2'b01};
  assign sq_ge     = (sq_rem_sh >= sq_trial);

  assign dv_sh = {drem_r, num_r[68]};
  assign dv_ge = (dv_sh >= {1'b0, dvs_r});

  assign dcl = (q_r > 69'(vssc_pkg::DELTA_CAP)) ? vssc_pkg::DELTA_CAP : q_r[40:0];
  assign sd  = (diff_neg_r ^ v_r[cmd.axis][32]) ? -$signed({1'b0, dcl})
                                                : $signed({1'b0, dcl});
  assign a_new = vssc_pkg::sat32($signed(ext32(pa_r[cmd.axis]) - {{2{sd[41]}}, sd}));
  assign b_new = vssc_pkg::sat32($signed(ext32(pb_r[cmd.axis]) + {{2{sd[41]}}, sd}));

  // memory port control
  always_comb begin
    cur_we  = 1'b0;
    prev_we = 1'b0;
    att_we  = 1'b0;
    spr_we  = 1'b0;
    cur_re  = 1'b0;
    prev_re = 1'b0;
    att_re  = 1'b0;
    spr_re  = 1'b0;
    cur_wa  = PAW'(cmd.idx);
    cur_ra1 = PAW'(in_slot);
    cur_ra2 = PAW'(sb_r);
    prev_a  = PAW'(cmd.idx);
    att_a   = AAW'(cmd.idx);
    spr_a   = SAW'(cmd.idx);
    cur_wd  = verlet_pos;
    prev_wd = cur_q1;
    unique case (cmd.code)
      vssc_pkg::CMD_ACCEPT: begin
        cur_wa  = PAW'(in_slot);
        prev_a  = PAW'(in_slot);
        att_a   = AAW'(in_slot);
        spr_a   = SAW'(in_slot);
        cur_wd  = in_pos;
        prev_wd = in_pos;
        unique case (in_operation)
          vssc_pkg::OP_LOAD_POINT: begin
            cur_we  = slot_pt_ok;
            prev_we = slot_pt_ok;
          end
          vssc_pkg::OP_LOAD_ATTACH: att_we = slot_att_ok;
          vssc_pkg::OP_LOAD_SPRING: spr_we = slot_spr_ok;
          vssc_pkg::OP_READ_POINT:  cur_re = slot_pt_ok;
          default: ;
        endcase
      end
      vssc_pkg::CMD_V_RD: begin
        cur_ra1 = PAW'(cmd.idx);
        cur_re  = 1'b1;
        prev_re = 1'b1;
      end
      vssc_pkg::CMD_V_WR: begin
        cur_we  = 1'b1;
        prev_we = 1'b1;
      end
      vssc_pkg::CMD_A_RD: att_re = 1'b1;
      vssc_pkg::CMD_A_WR: begin
        cur_wa = PAW'(att_pt);
        cur_wd = att_pos;
        cur_we = att_pt_ok;
      end
      vssc_pkg::CMD_S_RD: spr_re = 1'b1;
      vssc_pkg::CMD_S_PT: begin
        cur_ra1 = PAW'(spr_pa);
        cur_ra2 = PAW'(spr_pb);
        cur_re  = 1'b1;
      end
      vssc_pkg::CMD_WR_A: begin
        cur_wa = PAW'(sa_r);
        cur_wd = pa_r;
        cur_we = 1'b1;
      end
      vssc_pkg::CMD_WR_B: begin
        cur_wa = PAW'(sb_r);
        cur_wd = pb_r;
        cur_we = 1'b1;
      end
      default: ;
    endcase
  end

  // arithmetic sequencing
  always_ff @(posedge clk) begin
    unique case (cmd.code)
      vssc_pkg::CMD_ADV_START: begin
        adv_slot_r <= in_slot;
        t2_r       <= 17'((32'(ts_r) * 32'(ts_r) + 32'h8000) >> 16);
      end
      vssc_pkg::CMD_DROP: begin
        drop_r <= 20'((37'(vssc_pkg::GRAVITY_Q16) * 37'(t2_r) + 37'h8000) >> 16);
      end
      vssc_pkg::CMD_S_PT: begin
        sa_r   <= spr_pa;
        sb_r   <= spr_pb;
        rest_r <= spr_q[30:0];
      end
      vssc_pkg::CMD_S_V: begin
        pa_r  <= cur_q1;
        pb_r  <= cur_q2;
        acc_r <= '0;
        for (int j = 0; j < 3; j++) begin
          v_r[j] <= $signed({cur_q1[j][31], cur_q1[j]}) - $signed({cur_q2[j][31], cur_q2[j]});
        end
      end
      vssc_pkg::CMD_SQ: acc_r <= acc_r + 66'(vmag * vmag);
      vssc_pkg::CMD_SQRT_INIT: begin
        src_r  <= {4'b0, acc_r};
        rem_r  <= '0;
        root_r <= '0;
      end
      vssc_pkg::CMD_SQRT_STEP: begin
        src_r  <= {src_r[67:0], 2'b00};
        rem_r  <= sq_ge ? 37'(sq_rem_sh - sq_trial) : sq_rem_sh[36:0];
        root_r <= {root_r[33:0], sq_ge};
      end
      vssc_pkg::CMD_DIFF: begin
        diff_neg_r <= diff[35];
        dmag_r     <= diff[35] ? 36'(-diff) : 36'(diff);
        dvs_r      <= {root_r, 1'b0};
      end
      vssc_pkg::CMD_MUL_LO: mul_r <= 53'(dmag_r * vmag[16:0]);
      vssc_pkg::CMD_MUL_HI: begin
        prod_r <= 69'(mul_r) + {52'(dmag_r * vmag[32:17]), 17'b0};
      end
      vssc_pkg::CMD_DIV_INIT: begin
        num_r  <= prod_r;
        drem_r <= '0;
        q_r    <= '0;
      end
      vssc_pkg::CMD_DIV_STEP: begin
        num_r  <= {num_r[67:0], 1'b0};
        drem_r <= dv_ge ? 36'(dv_sh - {1'b0, dvs_r}) : dv_sh[35:0];
        q_r    <= {q_r[67:0], dv_ge};
      end
      vssc_pkg::CMD_APPLY: begin
        pa_r[cmd.axis] <= a_new;
        pb_r[cmd.axis] <= b_new;
      end
      default: ;
    endcase
  end

  // degenerate counter and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r       <= '0;
      out_valid_r <= 1'b0;
      out_rd_r    <= 1'b0;
      out_index_r <= '0;
      out_deg_r   <= '0;
    end else begin
      out_valid_r <= 1'b0;
      priority case (cmd.code)
        vssc_pkg::CMD_ACCEPT: begin
          out_valid_r <= 1'b1;
          out_index_r <= in_slot;
          out_rd_r    <= (in_operation == vssc_pkg::OP_READ_POINT) && slot_pt_ok;
          out_deg_r   <= '0;
        end
        vssc_pkg::CMD_ADV_START: deg_r <= '0;
        vssc_pkg::CMD_DEGEN:     deg_r <= deg_r + 11'd1;
        vssc_pkg::CMD_FIN: begin
          out_valid_r <= 1'b1;
          out_index_r <= adv_slot_r;
          out_rd_r    <= 1'b0;
          out_deg_r   <= deg_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_index              = out_index_r;
  assign out_x                  = out_rd_r ? cur_q1[0] : 32'd0;
  assign out_y                  = out_rd_r ? cur_q1[1] : 32'd0;
  assign out_z                  = out_rd_r ? cur_q1[2] : 32'd0;
  assign out_degenerate_springs = out_deg_r;

endmodule
